FILE: hdl/dlh_pkg.sv
// Shared types, widths and codes for the dynamic line hull.
// Used by the interfaces, the multiplier, the top level and the checker.
`default_nettype none

package dlh_pkg;

  localparam int DLH_CAPACITY   = 256;
  localparam int DLH_CNT_W      = $clog2(DLH_CAPACITY + 1);
  localparam int SLOPE_W        = 33;
  localparam int ICPT_W         = 63;
  localparam int LINE_W         = SLOPE_W + ICPT_W;
  localparam int VALUE_W        = 64;
  localparam int MAG_W          = 61;
  localparam int CFG_DATA_W     = 64;
  localparam int MUL_A_W        = 64;
  localparam int MUL_B_W        = 34;
  localparam int PROD_W         = MUL_A_W + MUL_B_W;
  localparam logic [MAG_W-1:0] MAG_RESET = MAG_W'(64'd1000000000000000);

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [ICPT_W-1:0]  icpt;
  } line_t;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DROP = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MINIMIZE  = 2'd0,
    REG_EMPTY_MAG = 2'd1
  } reg_index_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RM,
    S_RM_WR,
    S_INS,
    S_INS_WR,
    S_CTL,
    S_MU_R0,
    S_MU_R1,
    S_MU_R2,
    S_MU_R3,
    S_MUL_L,
    S_MUL_R,
    S_Q_RD,
    S_Q_MUL,
    S_Q_ACC,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_EQ,
    PH_MID0,
    PH_MIDW,
    PH_DROP,
    PH_LEFT0,
    PH_LEFTW,
    PH_RIGHT0,
    PH_RIGHTW
  } phase_t;

endpackage

`default_nettype wire

FILE: hdl/dlh_req_if.sv
// Request channel of the dynamic line hull: valid, ready and one input item.
// Depends on dlh_pkg.
`default_nettype none

interface dlh_req_if import dlh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] slope;
  logic signed [61:0] intercept;
  logic signed [31:0] query_x;

  modport source (output valid, action, slope, intercept, query_x, input ready);
  modport sink (input valid, action, slope, intercept, query_x, output ready);
endinterface

`default_nettype wire

FILE: hdl/dlh_rsp_if.sv
// Response channel of the dynamic line hull: valid, ready and one result item.
// Depends on dlh_pkg.
`default_nettype none

interface dlh_rsp_if import dlh_pkg::*; #(parameter int CNT_W = DLH_CNT_W) ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      hull_empty;
  status_t                   status;
  logic [CNT_W-1:0]          line_count;

  modport source (output valid, value, hull_empty, status, line_count, input ready);
  modport sink (input valid, value, hull_empty, status, line_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/dlh_cfg_if.sv
// Configuration write channel of the dynamic line hull: valid, ready, index and data.
// Depends on dlh_pkg.
`default_nettype none

interface dlh_cfg_if import dlh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dlh_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module dlh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/dlh_mul.sv
// Iterative signed multiplier, one partial product per cycle, for breakpoint tests.
// Depends on dlh_pkg.
`default_nettype none

module dlh_mul import dlh_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic                    done,
  output logic      [PROD_W-1:0]  p
);

  localparam int CNT_W = $clog2(MUL_B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_B_W - 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  mcand;
  logic [MUL_B_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // The top bit of the multiplier has negative weight.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      p      <= '0;
      mcand  <= {{(PROD_W - MUL_A_W){a[MUL_A_W-1]}}, a};
      mplier <= b;
      cnt    <= '0;
    end else if (busy) begin
      if (mplier[0]) begin
        p <= (cnt == LAST) ? p - mcand : p + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      cnt    <= cnt + CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dynamic_line_hull.sv
// Dynamic line hull: upper envelope of lines (negated when minimizing) kept sorted by slope in one RAM.
// Query: reads each stored line and evaluates it at x; an empty query and a clear go straight to the response.
// Add: scans the stored lines and shifts entries to make room, and runs the iterative
// multiplier twice for each breakpoint test.
// One transaction at a time. Synchronous reset empties the hull; RAM contents are not reset.
`default_nettype none

module dynamic_line_hull import dlh_pkg::*; #(
  parameter int CAPACITY = DLH_CAPACITY
) (
  input wire logic clk,
  input wire logic rst,
  dlh_cfg_if.sink  cfg,
  dlh_req_if.sink  req,
  dlh_rsp_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  state_t state, state_next;
  phase_t phase;

  logic [CW-1:0]      size, pos, idx;
  logic [CW-1:0]      idx_p1, idx_p2, idx_m1;
  logic [CW:0]        pos_p2w;
  logic [SLOPE_W-1:0] nm;
  logic [ICPT_W-1:0]  nb;
  logic signed [31:0] qx;
  logic               minimize;
  logic [MAG_W-1:0]   mag;
  line_t              l0, l1, l2, rd;
  logic [PROD_W-1:0]  lh;
  logic               mu_res;
  logic [VALUE_W-1:0] prod, best, val, v, newbest;
  logic signed [64:0] qprod_full;
  logic [ICPT_W-1:0]  qb;
  logic               best_vld, empty, out_free;
  status_t            status;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  line_t              ram_wdata;
  logic [LINE_W-1:0]  ram_rdata;
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  mul_p;

  dlh_ram #(.WIDTH(LINE_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  dlh_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  assign rd         = line_t'(ram_rdata);
  assign idx_p1     = idx + CW'(1);
  assign idx_p2     = idx + CW'(2);
  assign idx_m1     = idx - CW'(1);
  assign pos_p2w    = {1'b0, pos} + (CW + 1)'(2);
  assign qprod_full = $signed(rd.slope) * qx;
  assign v          = prod + {qb[ICPT_W-1], qb};
  assign newbest    = (!best_vld || $signed(v) > $signed(best)) ? v : best;
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_wdata  = rd;
    ram_raddr  = idx[AW-1:0];
    mul_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.action)
            ACT_ADD:   state_next = (size == CW'(CAPACITY)) ? S_DONE : S_SCAN_RD;
            ACT_QUERY: state_next = (size == '0) ? S_DONE : S_Q_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SCAN_RD: begin
        state_next = (idx < size) ? S_SCAN_CHK : S_INS;
      end
      S_SCAN_CHK: begin
        if ($signed(rd.slope) < $signed(nm)) begin
          state_next = S_SCAN_RD;
        end else if (rd.slope == nm) begin
          state_next = ($signed(rd.icpt) < $signed(nb)) ? S_RM : S_DONE;
        end else begin
          state_next = S_INS;
        end
      end
      S_RM: begin
        ram_raddr  = idx_p1[AW-1:0];
        state_next = (idx_p1 < size) ? S_RM_WR : S_CTL;
      end
      S_RM_WR: begin
        ram_we     = 1'b1;
        state_next = S_RM;
      end
      S_INS: begin
        ram_raddr = idx_m1[AW-1:0];
        if (idx > pos) begin
          state_next = S_INS_WR;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = pos[AW-1:0];
          ram_wdata  = '{slope: nm, icpt: nb};
          state_next = S_CTL;
        end
      end
      S_INS_WR: begin
        ram_we     = 1'b1;
        state_next = S_INS;
      end
      S_CTL: begin
        case (phase)
          PH_EQ:    state_next = S_INS;
          PH_MID0:  state_next = (pos != '0 && pos + CW'(1) < size) ? S_MU_R0 : S_CTL;
          PH_MIDW:  state_next = mu_res ? S_RM : S_CTL;
          PH_DROP:  state_next = S_DONE;
          PH_LEFT0: state_next = (pos >= CW'(2)) ? S_MU_R0 : S_CTL;
          PH_LEFTW: state_next = mu_res ? S_RM : S_CTL;
          PH_RIGHT0: state_next = (pos_p2w < {1'b0, size}) ? S_MU_R0 : S_DONE;
          PH_RIGHTW: state_next = mu_res ? S_RM : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_MU_R0: begin
        state_next = S_MU_R1;
      end
      S_MU_R1: begin
        ram_raddr  = idx_p1[AW-1:0];
        state_next = S_MU_R2;
      end
      S_MU_R2: begin
        ram_raddr  = idx_p2[AW-1:0];
        state_next = S_MU_R3;
      end
      S_MU_R3: begin
        mul_start  = 1'b1;
        mul_a      = {l0.icpt[ICPT_W-1], l0.icpt} - {rd.icpt[ICPT_W-1], rd.icpt};
        mul_b      = {l1.slope[SLOPE_W-1], l1.slope} - {l0.slope[SLOPE_W-1], l0.slope};
        state_next = S_MUL_L;
      end
      S_MUL_L: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = {l0.icpt[ICPT_W-1], l0.icpt} - {l1.icpt[ICPT_W-1], l1.icpt};
          mul_b      = {l2.slope[SLOPE_W-1], l2.slope} - {l0.slope[SLOPE_W-1], l0.slope};
          state_next = S_MUL_R;
        end
      end
      S_MUL_R: begin
        if (mul_done) begin
          state_next = S_CTL;
        end
      end
      S_Q_RD: begin
        state_next = S_Q_MUL;
      end
      S_Q_MUL: begin
        state_next = S_Q_ACC;
      end
      S_Q_ACC: begin
        state_next = (idx_p1 < size) ? S_Q_RD : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size     <= '0;
      minimize <= 1'b1;
      mag      <= MAG_RESET;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_MINIMIZE:  minimize <= cfg.data[0];
          REG_EMPTY_MAG: mag <= cfg.data[MAG_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.action == ACT_CLEAR) begin
            size <= '0;
          end
        end
        S_RM: begin
          if (!(idx_p1 < size)) begin
            size <= size - CW'(1);
          end
        end
        S_INS: begin
          if (!(idx > pos)) begin
            size <= size + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          nm       <= minimize ? SLOPE_W'(0) - {req.slope[31], req.slope}
                               : {req.slope[31], req.slope};
          nb       <= minimize ? ICPT_W'(0) - {req.intercept[61], req.intercept}
                               : {req.intercept[61], req.intercept};
          qx       <= req.query_x;
          idx      <= '0;
          best_vld <= 1'b0;
          status   <= ST_OK;
          val      <= '0;
          empty    <= 1'b0;
          if (req.action == ACT_ADD && size == CW'(CAPACITY)) begin
            status <= ST_FULL;
          end
          if (req.action == ACT_QUERY && size == '0) begin
            empty <= 1'b1;
            val   <= minimize ? {3'b000, mag} : VALUE_W'(0) - {3'b000, mag};
          end
        end
      end
      S_SCAN_RD: begin
        if (!(idx < size)) begin
          pos <= idx;
          idx <= size;
        end
      end
      S_SCAN_CHK: begin
        if ($signed(rd.slope) < $signed(nm)) begin
          idx <= idx_p1;
        end else begin
          pos <= idx;
          if (rd.slope == nm) begin
            phase <= PH_EQ;
            if (!($signed(rd.icpt) < $signed(nb))) begin
              status <= ST_DROP;
            end
          end else begin
            idx <= size;
          end
        end
      end
      S_RM_WR: idx <= idx_p1;
      S_INS: begin
        if (!(idx > pos)) begin
          phase <= PH_MID0;
        end
      end
      S_INS_WR: idx <= idx_m1;
      S_CTL: begin
        case (phase)
          PH_EQ: idx <= size;
          PH_MID0: begin
            if (pos != '0 && pos + CW'(1) < size) begin
              idx   <= pos - CW'(1);
              phase <= PH_MIDW;
            end else begin
              phase <= PH_LEFT0;
            end
          end
          PH_MIDW: begin
            if (mu_res) begin
              idx   <= pos;
              phase <= PH_DROP;
            end else begin
              phase <= PH_LEFT0;
            end
          end
          PH_DROP: status <= ST_DROP;
          PH_LEFT0: begin
            if (pos >= CW'(2)) begin
              idx   <= pos - CW'(2);
              phase <= PH_LEFTW;
            end else begin
              phase <= PH_RIGHT0;
            end
          end
          PH_LEFTW: begin
            if (mu_res) begin
              idx   <= pos - CW'(1);
              pos   <= pos - CW'(1);
              phase <= PH_LEFT0;
            end else begin
              phase <= PH_RIGHT0;
            end
          end
          PH_RIGHT0: begin
            if (pos_p2w < {1'b0, size}) begin
              idx   <= pos;
              phase <= PH_RIGHTW;
            end
          end
          PH_RIGHTW: begin
            if (mu_res) begin
              idx   <= pos + CW'(1);
              phase <= PH_RIGHT0;
            end
          end
          default: ;
        endcase
      end
      S_MU_R1: l0 <= rd;
      S_MU_R2: l1 <= rd;
      S_MU_R3: l2 <= rd;
      S_MUL_L: begin
        if (mul_done) begin
          lh <= mul_p;
        end
      end
      S_MUL_R: begin
        if (mul_done) begin
          mu_res <= $signed(lh) <= $signed(mul_p);
        end
      end
      S_Q_MUL: begin
        prod <= qprod_full[VALUE_W-1:0];
        qb   <= rd.icpt;
      end
      S_Q_ACC: begin
        best     <= newbest;
        best_vld <= 1'b1;
        idx      <= idx_p1;
        val      <= minimize ? VALUE_W'(0) - newbest : newbest;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.value      <= val;
      rsp.hull_empty <= empty;
      rsp.status     <= status;
      rsp.line_count <= size;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dlh_checker.sv
// Port-level checker for the dynamic line hull, bound to the top level.
// Depends on dlh_pkg and dynamic_line_hull.
`default_nettype none

module dlh_checker import dlh_pkg::*; #(
  parameter int CAPACITY = DLH_CAPACITY
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic [VALUE_W-1:0]           rsp_value,
  input wire logic                         rsp_hull_empty,
  input wire status_t                      rsp_status,
  input wire logic [$clog2(CAPACITY+1)-1:0] rsp_line_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  // A response transaction that is not taken stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response withdrawn before it was taken");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while previous one is in progress");

  a_empty_query: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hull_empty |-> rsp_line_count == '0 && rsp_status == ST_OK)
    else $error("empty query with stored lines or non-zero status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_FULL |-> rsp_line_count == CW'(CAPACITY))
    else $error("table full reported below capacity");

  a_add_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == '0 && !rsp_hull_empty)
    else $error("add response carries a query value");

endmodule

bind dynamic_line_hull dlh_checker #(.CAPACITY(CAPACITY)) u_dlh_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_value(rsp.value),
  .rsp_hull_empty(rsp.hull_empty),
  .rsp_status(rsp.status),
  .rsp_line_count(rsp.line_count)
);

`default_nettype wire

FILE: verif/dynamic_line_hull_tb.sv
// Self-checking testbench for the dynamic line hull: random and directed add, query, clear
// and unused-action transactions are checked against an in-bench envelope predictor.
// Depends on dlh_pkg, the three channel interfaces and dynamic_line_hull in hdl.
`default_nettype none

module dynamic_line_hull_tb;
  import dlh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]         action;
    logic signed [31:0] slope;
    logic signed [61:0] icpt;
    logic signed [31:0] x;
  } hull_op_t;

  typedef struct {
    logic signed [63:0] value;
    logic               empty;
    status_t            status;
    logic [8:0]         count;
  } hull_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dlh_cfg_if cfg_ch();
  dlh_req_if req_ch();
  dlh_rsp_if rsp_ch();

  dynamic_line_hull i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Envelope predictor state.
  longint      env_slope [DLH_CAPACITY];
  longint      env_icpt [DLH_CAPACITY];
  int          env_lines = 0;
  logic        env_minimize = 1'b1;
  logic [60:0] env_mag = MAG_RESET;

  hull_op_t     op_feed[$];
  hull_result_t expected_results[$];
  int           mismatches = 0;
  int           cycle_no = 0;
  int           hold_requests = 0;
  int           holds_served = 0;
  int           hold_left = 0;

  function automatic bit middle_dominated(int i, int j, int k);
    logic signed [127:0] a, b, c, d;
    a = env_icpt[i] - env_icpt[k];
    b = env_slope[j] - env_slope[i];
    c = env_icpt[i] - env_icpt[j];
    d = env_slope[k] - env_slope[i];
    return (a * b) <= (c * d);
  endfunction

  function automatic void drop_line(int p);
    for (int i = p; i + 1 < env_lines; i++) begin
      env_slope[i] = env_slope[i + 1];
      env_icpt[i] = env_icpt[i + 1];
    end
    env_lines--;
  endfunction

  function automatic status_t insert_line(longint m, longint b);
    int pos;
    pos = 0;
    if (env_minimize) begin
      m = -m;
      b = -b;
    end
    if (env_lines >= DLH_CAPACITY) return ST_FULL;
    while (pos < env_lines && env_slope[pos] < m) pos++;
    if (pos < env_lines && env_slope[pos] == m) begin
      if (env_icpt[pos] < b) drop_line(pos);
      else return ST_DROP;
    end
    for (int i = env_lines; i > pos; i--) begin
      env_slope[i] = env_slope[i - 1];
      env_icpt[i] = env_icpt[i - 1];
    end
    env_slope[pos] = m;
    env_icpt[pos] = b;
    env_lines++;
    if (pos > 0 && pos + 1 < env_lines && middle_dominated(pos - 1, pos, pos + 1)) begin
      drop_line(pos);
      return ST_DROP;
    end
    while (pos >= 2 && middle_dominated(pos - 2, pos - 1, pos)) begin
      drop_line(pos - 1);
      pos--;
    end
    while (pos + 2 < env_lines && middle_dominated(pos, pos + 1, pos + 2))
      drop_line(pos + 1);
    return ST_OK;
  endfunction

  function automatic hull_result_t apply_hull_op(hull_op_t op);
    hull_result_t r;
    longint best, v, x;
    r.value = '0;
    r.empty = 1'b0;
    r.status = ST_OK;
    if (op.action == ACT_ADD) begin
      r.status = insert_line(longint'(op.slope), longint'(op.icpt));
    end else if (op.action == ACT_QUERY) begin
      if (env_lines == 0) begin
        r.empty = 1'b1;
        r.value = env_minimize ? {3'b0, env_mag} : -{3'b0, env_mag};
      end else begin
        x = longint'(op.x);
        best = env_slope[0] * x + env_icpt[0];
        for (int i = 1; i < env_lines; i++) begin
          v = env_slope[i] * x + env_icpt[i];
          if (v > best) best = v;
        end
        r.value = env_minimize ? -best : best;
      end
    end else if (op.action == ACT_CLEAR) begin
      env_lines = 0;
    end
    r.count = 9'(env_lines);
    return r;
  endfunction

  function automatic bit quiet_stretch();
    return (cycle_no % 40000) < 8000;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_hull_op('{req_ch.action, req_ch.slope,
                                                   req_ch.intercept, req_ch.query_x}));
      end
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (op_feed.size() > 0 && (quiet_stretch() || $urandom_range(99) >= 6)) begin
          hull_op_t op;
          op = op_feed.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.action <= op.action;
          req_ch.slope <= op.slope;
          req_ch.intercept <= op.icpt;
          req_ch.query_x <= op.x;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and ready generation.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result transaction: value %0d", rsp_ch.value);
        end else begin
          hull_result_t e;
          e = expected_results.pop_front();
          if (rsp_ch.value !== e.value || rsp_ch.hull_empty !== e.empty ||
              rsp_ch.status !== e.status || rsp_ch.line_count !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Result mismatch: expected value %0d empty %0b status %0d ",
                        "count %0d, got value %0d empty %0b status %0d count %0d"},
                       e.value, e.empty, e.status, e.count, rsp_ch.value,
                       rsp_ch.hull_empty, rsp_ch.status, rsp_ch.line_count);
          end
        end
      end
      if (holds_served < hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet_stretch() || $urandom_range(99) >= 6;
      end
    end
  end

  function automatic hull_op_t make_op(logic [1:0] a, longint m, longint b, longint x);
    hull_op_t op;
    op.action = a;
    op.slope = 32'(m);
    op.icpt = 62'(b);
    op.x = 32'(x);
    return op;
  endfunction

  function automatic hull_op_t random_op();
    hull_op_t op;
    int pick;
    pick = $urandom_range(99);
    op.action = pick < 52 ? ACT_ADD : pick < 94 ? ACT_QUERY :
                pick < 97 ? ACT_CLEAR : ACT_UNUSED;
    if ($urandom_range(9) < 7) begin
      op.slope = 32'(int'($urandom_range(40)) - 20);
      op.icpt = 62'(int'($urandom_range(400)) - 200);
    end else begin
      op.slope = $urandom;
      op.icpt = 62'({$urandom, $urandom});
    end
    op.x = $urandom_range(9) < 6 ? 32'(int'($urandom_range(60)) - 30) : 32'($urandom);
    return op;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [63:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MINIMIZE) env_minimize = d[0];
    else env_mag = d[60:0];
  endtask

  task automatic wait_drained();
    while (op_feed.size() > 0 || req_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_random(int count);
    repeat (count) op_feed.push_back(random_op());
  endtask

  task automatic queue_directed();
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, 5));
    op_feed.push_back(make_op(ACT_ADD, 32'h7fffffff, 62'h1fffffffffffffff, 0));
    op_feed.push_back(make_op(ACT_ADD, -64'sd2147483648, -64'sh2000000000000000, 0));
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, 32'h7fffffff));
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, -64'sd2147483648));
    op_feed.push_back(make_op(ACT_CLEAR, 0, 0, 0));
    op_feed.push_back(make_op(ACT_ADD, 2, 10, 0));
    op_feed.push_back(make_op(ACT_ADD, 2, 10, 0));
    op_feed.push_back(make_op(ACT_ADD, 2, 4, 0));
    op_feed.push_back(make_op(ACT_ADD, 2, 20, 0));
    op_feed.push_back(make_op(ACT_ADD, -2, 0, 0));
    op_feed.push_back(make_op(ACT_ADD, 0, 100, 0));
    op_feed.push_back(make_op(ACT_ADD, 0, -100, 0));
    op_feed.push_back(make_op(ACT_ADD, 1, -50, 0));
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, 3));
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, -7));
    op_feed.push_back(make_op(ACT_UNUSED, 5, 5, 5));
    op_feed.push_back(make_op(ACT_CLEAR, 0, 0, 0));
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, 1));
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MINIMIZE;
    cfg_ch.data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_ADD;
    req_ch.slope = '0;
    req_ch.intercept = '0;
    req_ch.query_x = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    queue_directed();
    queue_random(300);
    wait_drained();

    write_reg(REG_MINIMIZE, {$urandom, $urandom} & ~64'd1);
    write_reg(REG_EMPTY_MAG, {3'b111, 61'h1fffffffffffffff});
    queue_directed();
    queue_random(150);
    hold_requests++;
    queue_random(350);
    wait_drained();

    write_reg(REG_MINIMIZE, 64'd1);
    write_reg(REG_EMPTY_MAG, 64'd0);
    queue_directed();
    queue_random(400);
    wait_drained();

    // Fill the table with lines that all stay on the envelope, then overflow it.
    op_feed.push_back(make_op(ACT_CLEAR, 0, 0, 0));
    for (int k = -128; k < 128; k++) op_feed.push_back(make_op(ACT_ADD, k, k * k, 0));
    op_feed.push_back(make_op(ACT_ADD, 500, 0, 0));
    op_feed.push_back(make_op(ACT_ADD, 0, -5, 0));
    op_feed.push_back(make_op(ACT_ADD, 0, 5, 0));
    for (int q = 0; q < 6; q++) op_feed.push_back(random_op());
    op_feed.push_back(make_op(ACT_QUERY, 0, 0, 0));
    wait_drained();

    // Mode change with lines still stored.
    write_reg(REG_MINIMIZE, 64'd0);
    write_reg(REG_EMPTY_MAG, {$urandom, $urandom});
    for (int q = 0; q < 4; q++) op_feed.push_back(make_op(ACT_QUERY, 0, 0, $urandom));
    op_feed.push_back(make_op(ACT_CLEAR, 0, 0, 0));
    queue_random(350);
    wait_drained();
    repeat (200) @(posedge clk);

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #150ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
hdl/dlh_pkg.sv
hdl/dlh_req_if.sv
hdl/dlh_rsp_if.sv
hdl/dlh_cfg_if.sv
hdl/dlh_ram.sv
hdl/dlh_mul.sv
hdl/dynamic_line_hull.sv
hdl/dlh_checker.sv
verif/dynamic_line_hull_tb.sv
